// ===== rtl/fsf_pkg.sv =====
// Shared types, constants and CRC helper for the firmware section framer.
`default_nettype none

package fsf_pkg;

  // Framing constants
  localparam int SECTION_BYTES = 508;
  localparam int LENGTH_BITS   = 24;
  localparam int HEADER_BYTES  = 16;
  localparam int POS_BITS      = $clog2(SECTION_BYTES + 1);
  localparam int IDX_BITS      = $clog2(HEADER_BYTES);

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

  // Header type codes
  localparam logic [31:0] SEC_TYPE = 32'd1;
  localparam logic [31:0] END_TYPE = 32'd4;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_LENGTH = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOAD_ADDRESS = 1'b1;

  // Command queue depth (power of two)
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  // One classified input byte, handed from front to back
  typedef struct packed {
    logic [7:0]  data;
    logic        start;      // byte opens a section: header goes first
    logic        last_sec;   // byte closes a section: section CRC follows
    logic        last_img;   // byte closes the image: end header follows
    logic [31:0] hdr_addr;   // load address plus section offset
    logic [31:0] hdr_size;   // section size plus four
  } cmd_t;

  // CRC-32, MSB first, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'h00_0000};
    for (int k = 0; k < 8; k++) begin
      if (c[31]) begin
        c = {c[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[30:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fsf_if.sv =====
// Stream interfaces: binary byte input and framed byte output.
`default_nettype none

interface fsf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface fsf_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       image_end;

  modport source (output valid, output out_byte, output run_end, output image_end,
                  input ready);
  modport sink (input valid, input out_byte, input run_end, input image_end,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/fsf_queue.sv =====
// Small command FIFO between the front classifier and the back sequencer.
`default_nettype none

module fsf_queue
  import fsf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      full,
  output logic      empty
);

  cmd_t                 mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;

  assign full  = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fsf_front.sv =====
// Front end: config registers, byte acceptance and section classification.
`default_nettype none

module fsf_front
  import fsf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [31:0]             cfg_data,
  fsf_byte_if.sink                     din,
  input  wire logic                    q_full,
  output logic                         push,
  output cmd_t                         push_cmd,
  output logic [31:0]                  load_address
);

  logic [LENGTH_BITS-1:0] total_length;
  logic [LENGTH_BITS-1:0] byte_offset;
  logic [POS_BITS-1:0]    section_position;

  logic [LENGTH_BITS-1:0] remaining;
  logic [LENGTH_BITS-1:0] sec_size;
  logic                   in_range;
  logic                   accept;
  logic                   last_img;
  logic                   last_sec;

  assign din.ready = !q_full;
  assign accept    = din.valid && din.ready;

  // Classify the incoming byte
  always_comb begin
    in_range  = (byte_offset < total_length);
    remaining = total_length - byte_offset;
    if (remaining < LENGTH_BITS'(SECTION_BYTES)) begin
      sec_size = remaining;
    end else begin
      sec_size = LENGTH_BITS'(SECTION_BYTES);
    end
    last_img = (remaining == LENGTH_BITS'(1));
    last_sec = last_img || (section_position == POS_BITS'(SECTION_BYTES - 1));

    push              = accept && in_range;
    push_cmd.data     = din.data_byte;
    push_cmd.start    = (section_position == '0);
    push_cmd.last_sec = last_sec;
    push_cmd.last_img = last_img;
    push_cmd.hdr_addr = load_address + 32'(byte_offset);
    push_cmd.hdr_size = 32'(sec_size) + 32'd4;
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      total_length <= LENGTH_BITS'(1);
      load_address <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TOTAL_LENGTH: total_length <= cfg_data[LENGTH_BITS-1:0];
        CFG_LOAD_ADDRESS: load_address <= cfg_data;
        default: ;
      endcase
    end
  end

  // Image progress counters
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset      <= '0;
      section_position <= '0;
    end else if (push) begin
      byte_offset <= byte_offset + 1'b1;
      if (last_sec) begin
        section_position <= '0;
      end else begin
        section_position <= section_position + 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fsf_back.sv =====
// Back end: expands each command into header, data, CRC and end-header bytes.
`default_nettype none

module fsf_back
  import fsf_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire cmd_t  head,
  input  wire logic  q_empty,
  output logic       pop,
  input  wire logic [31:0] load_address,
  fsf_frame_if.source dout
);

  typedef enum logic [1:0] {
    PH_HDR,
    PH_DATA,
    PH_CRC,
    PH_FHDR
  } phase_t;

  localparam logic [IDX_BITS-1:0] IDX_LAST  = IDX_BITS'(HEADER_BYTES - 1);
  localparam logic [IDX_BITS-1:0] IDX_CRC   = IDX_BITS'(HEADER_BYTES - 4);
  localparam logic [IDX_BITS-1:0] CRC_LAST  = IDX_BITS'(3);

  phase_t              phase;
  logic [IDX_BITS-1:0] idx;
  logic                busy;
  logic [31:0]         hcrc;
  logic [31:0]         scrc;
  logic                out_valid;
  logic [7:0]          out_byte;
  logic                run_end;
  logic                image_end;

  phase_t              cur_phase;
  logic [IDX_BITS-1:0] cur_idx;
  logic                advance;
  phase_t              phase_next;
  logic [IDX_BITS-1:0] idx_next;
  logic                busy_next;
  logic [31:0]         hcrc_next;
  logic [31:0]         scrc_next;
  logic [7:0]          byte_next;
  logic                run_end_next;
  logic                image_end_next;
  logic [31:0]         hdr_word;
  logic [31:0]         hdr_shifted;
  logic [31:0]         hcrc_shifted;
  logic [31:0]         scrc_shifted;
  logic                is_end_hdr;

  assign advance = !q_empty && (!out_valid || dout.ready);
  assign pop     = advance && !busy_next;

  assign dout.valid     = out_valid;
  assign dout.out_byte  = out_byte;
  assign dout.run_end   = run_end;
  assign dout.image_end = image_end;

  // Byte sources for the current step
  always_comb begin
    cur_phase  = busy ? phase : (head.start ? PH_HDR : PH_DATA);
    cur_idx    = busy ? idx : '0;
    is_end_hdr = (cur_phase == PH_FHDR);
    case (cur_idx[3:2])
      2'd0:    hdr_word = is_end_hdr ? END_TYPE : SEC_TYPE;
      2'd1:    hdr_word = is_end_hdr ? load_address : head.hdr_addr;
      2'd2:    hdr_word = is_end_hdr ? load_address : head.hdr_size;
      default: hdr_word = '0;
    endcase
    hdr_shifted  = hdr_word >> {cur_idx[1:0], 3'b000};
    hcrc_shifted = hcrc >> {~cur_idx[1:0], 3'b000};
    scrc_shifted = scrc >> {~cur_idx[1:0], 3'b000};
  end

  // Sequencer next state
  always_comb begin
    phase_next     = cur_phase;
    idx_next       = cur_idx + 1'b1;
    busy_next      = 1'b1;
    hcrc_next      = hcrc;
    scrc_next      = scrc;
    byte_next      = 8'h00;
    run_end_next   = 1'b0;
    image_end_next = 1'b0;
    case (cur_phase)
      PH_HDR, PH_FHDR: begin
        if (cur_idx < IDX_CRC) begin
          byte_next = hdr_shifted[7:0];
          hcrc_next = crc_byte((cur_idx == '0) ? 32'h0 : hcrc, hdr_shifted[7:0]);
        end else begin
          byte_next = hcrc_shifted[7:0];
        end
        if (cur_idx == IDX_LAST) begin
          idx_next = '0;
          if (cur_phase == PH_HDR) begin
            phase_next = PH_DATA;
          end else begin
            busy_next      = 1'b0;
            run_end_next   = 1'b1;
            image_end_next = 1'b1;
          end
        end
      end
      PH_DATA: begin
        byte_next = head.data;
        scrc_next = crc_byte(head.start ? 32'h0 : scrc, head.data);
        idx_next  = '0;
        if (head.last_sec) begin
          phase_next = PH_CRC;
        end else begin
          busy_next    = 1'b0;
          run_end_next = 1'b1;
        end
      end
      PH_CRC: begin
        byte_next = scrc_shifted[7:0];
        if (cur_idx == CRC_LAST) begin
          idx_next = '0;
          if (head.last_img) begin
            phase_next = PH_FHDR;
          end else begin
            busy_next    = 1'b0;
            run_end_next = 1'b1;
          end
        end
      end
      default: begin
        busy_next = 1'b0;
      end
    endcase
  end

  // Sequencer state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DATA;
      idx       <= '0;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      phase     <= phase_next;
      idx       <= idx_next;
      busy      <= busy_next;
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      hcrc      <= hcrc_next;
      scrc      <= scrc_next;
      out_byte  <= byte_next;
      run_end   <= run_end_next;
      image_end <= image_end_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/firmware_section_framer.sv =====
// An accepted byte enters the command queue, then the back sequencer registers
// its first framed byte. Throughput: one framed byte per cycle while dout is
// ready and a command is queued; a section start adds 16 header bytes, a
// section end 4 CRC bytes, the image end 16 bytes; one output path sets this.
// Reset (synchronous): total_length 1, load_address 0, counters and queue clear.
`default_nettype none

module firmware_section_framer
  import fsf_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [31:0]             cfg_data,
  fsf_byte_if.sink                     din,
  fsf_frame_if.source                  dout
);

  cmd_t        push_cmd;
  cmd_t        head;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_empty;
  logic [31:0] load_address;

  // Accept and classify
  fsf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .din          (din),
    .q_full       (q_full),
    .push         (push),
    .push_cmd     (push_cmd),
    .load_address (load_address)
  );

  // Decoupling queue
  fsf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Byte sequencer
  fsf_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .load_address (load_address),
    .dout         (dout)
  );

endmodule

`default_nettype wire
